>>> rtl/r64a_pkg.sv
package r64a_pkg;

   localparam int          MAX_CHARS  = 10;
   localparam int          CNT_W      = 4;
   localparam logic [23:0] CRC_INIT   = 24'hB704CE;
   localparam logic [23:0] CRC_POLY   = 24'h864CFB;  // x^24 term implied
   localparam logic [4:0]  GPL_RESET  = 5'd15;
   localparam logic [7:0]  PAD_CHAR   = 8'h3D;
   localparam logic [7:0]  NL_CHAR    = 8'h0A;

   typedef logic [7:0] char_type;
   typedef char_type   char_buf_type [MAX_CHARS];

   function automatic char_type b64_char(input logic [5:0] v);
      char_type c;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         c = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         c = 8'h2B;
      end else begin
         c = 8'h2F;
      end
      return c;
   endfunction

   function automatic logic [23:0] crc_update(input logic [23:0] crc, input logic [7:0] b);
      logic [23:0] c;
      c = crc ^ {b, 16'h0000};
      for (int k = 0; k < 8; k++) begin
         if (c[23]) begin
            c = {c[22:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[22:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> rtl/radix64_armor_crc24_encoder.sv
// Radix-64 armor body encoder with CRC-24 trailer. Message bytes enter one
// per beat on req_; ASCII text leaves one character per beat on rsp_. Every
// three bytes give four base64 characters, a newline follows each
// csr_wdata-configured number of groups, and the beat with req_tlast flushes
// the partial group with '=' padding, closes the line and appends '=' plus
// four CRC-24 characters (rsp_tlast on the last). A beat with req_tuser low
// carries no byte. An item is taken into an input register, encoded
// combinationally into a character buffer of up to 10 characters, and the
// buffer drains at one character per cycle while rsp_tready is high, so
// the rsp_ port sets the rate: a byte that completes a group loads 4 or 5
// characters, other beats none, and the closing beat up to 10.
// The next item is accepted while the buffer still drains.
module radix64_armor_crc24_encoder
   import r64a_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wen,
   input  logic [4:0] csr_wdata,    // line length in groups
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] data_byte
   input  logic       req_tuser,    // [0] carries_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] out_char
   output logic       rsp_tlast
);

   logic [4:0]       gpl_ff;
   logic             in_valid_ff;
   logic [7:0]       in_data_ff;
   logic             in_has_ff;
   logic             in_last_ff;

   logic [23:0]      crc_ff, crc_in;
   logic [15:0]      held_ff, held_in;
   logic [1:0]       held_cnt_ff, held_cnt_in;
   logic [4:0]       gil_ff, gil_in;

   char_buf_type     buf_ff, buf_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic             buf_last_ff, buf_last_in;

   logic             rsp_take;
   logic             buf_free;
   logic             load;
   logic [23:0]      word;
   logic [4:0]       gil_inc;

   assign rsp_take   = rsp_tvalid && rsp_tready;
   assign buf_free   = (rem_ff == '0) || ((rem_ff == CNT_W'(1)) && rsp_tready);
   assign load       = in_valid_ff && buf_free;
   assign req_tready = !in_valid_ff || load;

   assign rsp_tvalid = (rem_ff != '0);
   assign rsp_tdata  = buf_ff[0];
   assign rsp_tlast  = buf_last_ff && (rem_ff == CNT_W'(1));

   always_comb begin
      crc_in      = crc_ff;
      held_in     = held_ff;
      held_cnt_in = held_cnt_ff;
      gil_in      = gil_ff;
      rem_in      = '0;
      buf_last_in = 1'b0;
      word        = '0;
      gil_inc     = gil_ff + 5'd1;
      for (int i = 0; i < MAX_CHARS; i++) begin
         buf_in[i] = '0;
      end

      if (in_has_ff) begin
         crc_in = crc_update(crc_ff, in_data_ff);
         if (held_cnt_ff >= 2'd2) begin
            word = {held_ff, in_data_ff};
            buf_in[0]   = b64_char(word[23:18]);
            buf_in[1]   = b64_char(word[17:12]);
            buf_in[2]   = b64_char(word[11:6]);
            buf_in[3]   = b64_char(word[5:0]);
            rem_in      = CNT_W'(4);
            held_in     = '0;
            held_cnt_in = '0;
            gil_in      = gil_inc;
            if ((gil_inc == '0) || (gil_inc >= gpl_ff)) begin
               buf_in[4] = NL_CHAR;
               rem_in    = CNT_W'(5);
               gil_in    = '0;
            end
         end else begin
            held_in     = {held_ff[7:0], in_data_ff};
            held_cnt_in = held_cnt_ff + 2'd1;
         end
      end

      if (in_last_ff) begin
         if (held_cnt_in != '0) begin
            word = (held_cnt_in == 2'd1) ? {held_in[7:0], 16'h0000} : {held_in, 8'h00};
            buf_in[rem_in]            = b64_char(word[23:18]);
            buf_in[rem_in + CNT_W'(1)] = b64_char(word[17:12]);
            buf_in[rem_in + CNT_W'(2)] = (held_cnt_in == 2'd2) ? b64_char(word[11:6])
                                                               : PAD_CHAR;
            buf_in[rem_in + CNT_W'(3)] = PAD_CHAR;
            rem_in = rem_in + CNT_W'(4);
         end
         if ((held_cnt_in != '0) || (gil_in != '0)) begin
            buf_in[rem_in] = NL_CHAR;
            rem_in = rem_in + CNT_W'(1);
         end
         buf_in[rem_in]             = PAD_CHAR;
         buf_in[rem_in + CNT_W'(1)] = b64_char(crc_in[23:18]);
         buf_in[rem_in + CNT_W'(2)] = b64_char(crc_in[17:12]);
         buf_in[rem_in + CNT_W'(3)] = b64_char(crc_in[11:6]);
         buf_in[rem_in + CNT_W'(4)] = b64_char(crc_in[5:0]);
         rem_in      = rem_in + CNT_W'(5);
         buf_last_in = 1'b1;
         crc_in      = CRC_INIT;
         held_in     = '0;
         held_cnt_in = '0;
         gil_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gpl_ff      <= GPL_RESET;
         in_valid_ff <= 1'b0;
         crc_ff      <= CRC_INIT;
         held_ff     <= '0;
         held_cnt_ff <= '0;
         gil_ff      <= '0;
         rem_ff      <= '0;
         buf_last_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            gpl_ff <= csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
            in_data_ff  <= req_tdata;
            in_has_ff   <= req_tuser;
            in_last_ff  <= req_tlast;
         end else if (load) begin
            in_valid_ff <= 1'b0;
         end
         if (load) begin
            crc_ff      <= crc_in;
            held_ff     <= held_in;
            held_cnt_ff <= held_cnt_in;
            gil_ff      <= gil_in;
            buf_ff      <= buf_in;
            rem_ff      <= rem_in;
            buf_last_ff <= buf_last_in;
         end else if (rsp_take) begin
            for (int i = 0; i < MAX_CHARS - 1; i++) begin
               buf_ff[i] <= buf_ff[i+1];
            end
            rem_ff <= rem_ff - CNT_W'(1);
         end
      end
   end

   a_held_cnt_range: assert property (@(posedge clock) disable iff (reset)
      held_cnt_ff != 2'd3)
      else $error("held byte count out of range");

   a_clear_at_trailer: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |->
         held_cnt_ff == '0 && gil_ff == '0 && crc_ff == CRC_INIT)
      else $error("message state not cleared at trailer");

   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      load |=> rem_ff <= CNT_W'(MAX_CHARS))
      else $error("character buffer overfilled");

   a_trailer_char: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata != NL_CHAR && rsp_tdata != PAD_CHAR)
      else $error("final character is not a checksum character");

endmodule

>>> sim/armor_text_checker.sv
module armor_text_checker
   import r64a_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wen,
   input  logic [4:0] csr_wdata,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tuser,
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic       rsp_tlast,
   output int         mismatch_count,
   output int         chars_due
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [24:0]  CRC24_GEN = 25'h1864CFB;
   localparam logic [511:0] ALPHABET  =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      char_type ch;
      logic     fin;
   } text_char_type;

   text_char_type text_due [$];
   logic [4:0]  line_groups;
   logic [23:0] crc;
   logic [15:0] held;
   logic [1:0]  held_n;
   logic [4:0]  line_fill;

   function automatic char_type radix64_char(input logic [23:0] word, input int pos);
      logic [5:0] v;
      v = word[23 - 6 * pos -: 6];
      return ALPHABET[511 - 8 * v -: 8];
   endfunction

   function automatic logic [23:0] crc24_next(input logic [23:0] c, input logic [7:0] b);
      logic [24:0] r;
      r = {1'b0, c ^ {b, 16'h0000}};
      for (int k = 0; k < 8; k++) begin
         r = r << 1;
         if (r[24]) begin
            r = r ^ CRC24_GEN;
         end
      end
      return r[23:0];
   endfunction

   task automatic queue_char(input char_type c, input logic fin);
      text_char_type t;
      t.ch  = c;
      t.fin = fin;
      text_due.push_back(t);
   endtask

   task automatic clear_message();
      crc       = CRC_INIT;
      held      = '0;
      held_n    = '0;
      line_fill = '0;
   endtask

   task automatic encode_beat(input logic [7:0] b, input logic has, input logic fin);
      logic [23:0] word;
      if (has) begin
         crc = crc24_next(crc, b);
         if (held_n == 2'd2) begin
            word = {held, b};
            for (int k = 0; k < 4; k++) begin
               queue_char(radix64_char(word, k), 1'b0);
            end
            held      = '0;
            held_n    = '0;
            line_fill = line_fill + 5'd1;
            if (line_fill == 5'd0 || line_fill >= line_groups) begin
               queue_char(NL_CHAR, 1'b0);
               line_fill = '0;
            end
         end else begin
            held   = {held[7:0], b};
            held_n = held_n + 2'd1;
         end
      end
      if (fin) begin
         if (held_n != 2'd0) begin
            word = (held_n == 2'd1) ? {held[7:0], 16'h0000} : {held, 8'h00};
            queue_char(radix64_char(word, 0), 1'b0);
            queue_char(radix64_char(word, 1), 1'b0);
            queue_char((held_n == 2'd2) ? radix64_char(word, 2) : PAD_CHAR, 1'b0);
            queue_char(PAD_CHAR, 1'b0);
         end
         if (held_n != 2'd0 || line_fill != 5'd0) begin
            queue_char(NL_CHAR, 1'b0);
         end
         queue_char(PAD_CHAR, 1'b0);
         for (int k = 0; k < 4; k++) begin
            queue_char(radix64_char(crc, k), k == 3);
         end
         clear_message();
      end
   endtask

   always @(posedge clock) begin : watch
      text_char_type head;
      if (reset) begin
         line_groups = GPL_RESET;
         clear_message();
         text_due.delete();
         mismatch_count = 0;
      end else begin
         if (csr_wen) begin
            line_groups = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            encode_beat(req_tdata, req_tuser, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (text_due.size() == 0) begin
               $error("out_char: expected none, got %h (last_char %b)", rsp_tdata, rsp_tlast);
               mismatch_count++;
            end else begin
               head = text_due.pop_front();
               if (rsp_tdata !== head.ch) begin
                  $error("out_char: expected %h, got %h", head.ch, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tlast !== head.fin) begin
                  $error("last_char: expected %b, got %b", head.fin, rsp_tlast);
                  mismatch_count++;
               end
            end
         end
      end
      chars_due <= text_due.size();
   end

endmodule

>>> sim/tb_radix64_armor_crc24_encoder.sv
module tb_radix64_armor_crc24_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE       = 16;
   localparam int STALL_LIMIT  = 4000;
   localparam int ITEM_TARGET  = 100;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       csr_wen    = 1'b0;
   logic [4:0] csr_wdata  = '0;
   logic       req_tvalid = 1'b0;
   logic [7:0] req_tdata  = '0;
   logic       req_tuser  = 1'b0;
   logic       req_tlast  = 1'b0;
   logic       rsp_tready = 1'b0;
   logic       req_tready;
   logic       rsp_tvalid;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   int mismatch_count;
   int chars_due;
   int idle_cycles = 0;
   int items_sent  = 0;
   bit no_idle     = 1'b0;
   bit rsp_hold_req = 1'b0;

   always #4 clock = ~clock;

   radix64_armor_crc24_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   armor_text_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .csr_wen        (csr_wen),
      .csr_wdata      (csr_wdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .chars_due      (chars_due)
   );

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // sink side
   initial begin : sink
      int stall;
      wait (!reset);
      forever begin
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = no_idle ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_beat(input logic [7:0] b, input logic has, input logic fin);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= has;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (chars_due != 0) @(posedge clock);
   endtask

   task automatic write_line_groups(input logic [4:0] v);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   task automatic send_bytes(input int n, input bit close);
      bit byteless_close;
      byteless_close = close && (n == 0 || $urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         end
         send_beat(8'($urandom_range(0, 255)), 1'b1,
                   close && !byteless_close && i == n - 1);
      end
      if (byteless_close) begin
         send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
   endtask

   function automatic logic [4:0] pick_line_groups();
      case ($urandom_range(0, 4))
         0:       return 5'd0;
         1:       return 5'd1;
         2:       return 5'd19;
         3:       return 5'd31;
         default: return 5'($urandom_range(0, 31));
      endcase
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty message at the default line length
      send_beat(8'h00, 1'b0, 1'b1);
      // a full group of all ones, a byteless beat, then a two-byte tail of zeros
      send_beat(8'hFF, 1'b1, 1'b0);
      send_beat(8'hFF, 1'b1, 1'b0);
      send_beat(8'hFF, 1'b1, 1'b0);
      send_beat(8'hA5, 1'b0, 1'b0);
      send_beat(8'h00, 1'b1, 1'b0);
      send_beat(8'h00, 1'b1, 1'b1);

      write_line_groups(5'd1);
      send_beat(8'hFB, 1'b1, 1'b0);
      send_beat(8'hEF, 1'b1, 1'b0);
      send_beat(8'hBE, 1'b1, 1'b0);
      send_beat(8'h12, 1'b1, 1'b0);
      send_beat(8'h34, 1'b1, 1'b1);

      // zero acts as one; last beat completes a group
      write_line_groups(5'd0);
      send_beat(8'h80, 1'b1, 1'b0);
      send_beat(8'h01, 1'b1, 1'b0);
      send_beat(8'h7F, 1'b1, 1'b1);

      // byteless closing beat after a partial group
      write_line_groups(5'd31);
      send_beat(8'h55, 1'b1, 1'b0);
      send_beat(8'hAA, 1'b1, 1'b0);
      send_beat(8'hFF, 1'b0, 1'b1);

      // line length lowered mid-line
      write_line_groups(5'd19);
      send_bytes(6, 1'b0);
      write_line_groups(5'd2);
      send_bytes(3, 1'b1);

      // receiver holds off while the sender streams
      wait_drained();
      no_idle = 1'b1;
      rsp_hold_req = 1'b1;
      send_bytes(40, 1'b1);
      no_idle = 1'b0;

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 2) == 0) begin
            write_line_groups(pick_line_groups());
         end
         no_idle = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 5) == 0) begin
            send_bytes($urandom_range(1, 12), 1'b0);
            write_line_groups(pick_line_groups());
            send_bytes($urandom_range(0, 12), 1'b1);
         end else begin
            send_bytes($urandom_range(0, 20), 1'b1);
         end
      end
      no_idle = 1'b0;

      wait_drained();
      repeat (30) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
